FILE: rtl/olt_pkg.sv
package olt_pkg;

  // List geometry
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DELETE    = 3'd2,
    OP_FIND      = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // One write into the entry store
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_t;

endpackage

FILE: rtl/olt_store.sv
module olt_store (
  input  logic                          clk_i,
  input  olt_pkg::wr_t                  wr_i,
  input  logic [olt_pkg::IDX_W-1:0]     raddr_i,
  output logic [olt_pkg::DATA_W-1:0]    rdata_o
);
  import olt_pkg::*;

  logic [DATA_W-1:0] entries_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      entries_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Single registered read port: data follows the address on the next cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= entries_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ordered_list_table.sv
// Ordered list of up to 16 signed 32-bit entries, front at position 0.
// Input channel (in_valid_i/in_ready_o) carries one request beat: op_i,
// value_i and index_i. Output channel (out_valid_o/out_ready_i) returns one
// result beat per request: status_o, position_o, read_value_o and count_o,
// where count_o is the entry count after the request.
// One request is worked at a time; in_ready_o is high only while idle.
// A single pointer and one 32-bit equality compare step through the store,
// one entry per cycle; the store read is registered, so it is addressed ahead.
// Insert back, read and an unused op go straight to the result; insert front
// first shifts the entries toward the back; find scans until a match or the
// end of the list; delete scans, then shifts the later entries down.
// The next request is taken as soon as the result sits in the output
// register; if the receiver stalls with a result still waiting, the block
// holds the finished result internally until the output register frees.
// Reset empties the list (count zero); entry contents are not cleared.
module ordered_list_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [olt_pkg::OP_W-1:0]            op_i,
  input  logic signed [olt_pkg::DATA_W-1:0]   value_i,
  input  logic [olt_pkg::IDX_W-1:0]           index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [olt_pkg::STATUS_W-1:0]        status_o,
  output logic [olt_pkg::IDX_W-1:0]           position_o,
  output logic signed [olt_pkg::DATA_W-1:0]   read_value_o,
  output logic [olt_pkg::CNT_W-1:0]           count_o
);
  import olt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT_UP = 3'd3;
  localparam logic [2:0] S_SHIFT_DN = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [DATA_W-1:0]   value_q, value_d;
  logic [IDX_W-1:0]    index_q, index_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]   rd_q, rd_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [STATUS_W-1:0] out_status_q;
  logic [IDX_W-1:0]    out_pos_q;
  logic [DATA_W-1:0]   out_rd_q;
  logic [CNT_W-1:0]    out_count_q;

  wr_t                 wr;
  logic [IDX_W-1:0]    raddr;
  logic [DATA_W-1:0]   rdata;
  logic                hit;
  logic                last;

  olt_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared compare and end-of-list check on the pointer
  assign hit  = (rdata == value_q);
  assign last = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer; raddr picks the entry seen in rdata on the next cycle
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    count_d  = count_q;
    op_d     = op_q;
    value_d  = value_q;
    index_d  = index_q;
    status_d = status_q;
    pos_d    = pos_q;
    rd_d     = rd_q;
    wr       = '0;
    raddr    = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        raddr = index_i;
        if (in_valid_i) begin
          op_d    = op_i;
          value_d = value_i;
          index_d = index_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_d = ST_OK;
        pos_d    = '0;
        rd_d     = '0;
        state_d  = S_FINISH;
        unique case (op_q) inside
          OP_INS_FRONT: begin
            if (count_q == FULL_CNT) begin
              status_d = ST_FULL;
            end else begin
              raddr   = count_q[IDX_W-1:0] - IDX_W'(1);
              ptr_d   = count_q[IDX_W-1:0];
              state_d = S_SHIFT_UP;
            end
          end
          OP_INS_BACK: begin
            if (count_q == FULL_CNT) begin
              status_d = ST_FULL;
            end else begin
              wr.en   = 1'b1;
              wr.addr = count_q[IDX_W-1:0];
              wr.data = value_q;
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_DELETE, OP_FIND: begin
            if (count_q == '0) begin
              status_d = ST_NOT_FOUND;
            end else begin
              ptr_d   = '0;
              state_d = S_SCAN;
            end
          end
          OP_READ: begin
            if (CNT_W'(index_q) >= count_q) begin
              status_d = ST_BAD_INDEX;
            end else begin
              rd_d = rdata;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        // Move entries one place toward the back, then drop the value in front
        raddr = ptr_q - IDX_W'(2);
        wr.en = 1'b1;
        if (ptr_q == '0) begin
          wr.addr = '0;
          wr.data = value_q;
          count_d = count_q + CNT_W'(1);
          state_d = S_FINISH;
        end else begin
          wr.addr = ptr_q;
          wr.data = rdata;
          ptr_d   = ptr_q - IDX_W'(1);
        end
      end
      S_SCAN: begin
        raddr = ptr_q + IDX_W'(1);
        if (hit) begin
          pos_d   = ptr_q;
          state_d = (op_q == OP_DELETE) ? S_SHIFT_DN : S_FINISH;
        end else if (last) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_FINISH;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      S_SHIFT_DN: begin
        // Close the gap left by the deleted entry
        raddr = ptr_q + IDX_W'(2);
        if (last) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_FINISH;
        end else begin
          wr.en   = 1'b1;
          wr.addr = ptr_q;
          wr.data = rdata;
          ptr_d   = ptr_q + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    op_q     <= op_d;
    value_q  <= value_d;
    index_q  <= index_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    rd_q     <= rd_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_pos_q    <= pos_q;
      out_rd_q     <= rd_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign position_o   = out_pos_q;
  assign read_value_o = out_rd_q;
  assign count_o      = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count beyond depth");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_DISPATCH || $past(state_q) == S_SHIFT_UP ||
       $past(state_q) == S_SHIFT_DN))
    else $error("entry count changed outside an update step");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (count_o == FULL_CNT))
    else $error("full status with list not full");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOT_FOUND) |->
      (position_o == '0 && read_value_o == '0))
    else $error("not-found result carries nonzero fields");
`endif

endmodule
